// File: rtl/cross_median_denoise_core_defines.svh
// Assertion macros for the cross median denoise core.
// Included by the top level; no other dependencies.
`ifndef CROSS_MEDIAN_DENOISE_CORE_DEFINES_SVH
`define CROSS_MEDIAN_DENOISE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMDN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMDN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cmdn_pkg.sv
// Shared types and constants for the cross median denoise core.
// No dependencies; compiled before every other RTL file.
`default_nettype none

package cmdn_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

   // median window
   localparam int N_TAPS      = 5;
   localparam int RANK_W      = 3;
   localparam int MEDIAN_RANK = 2;

   // request mode codes
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // one line store word: pixel two rows up and pixel one row up
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } line_pair_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: rtl/cmdn_req_if.sv
// Request channel: mode and incoming pixel with valid/ready.
// Depends on cmdn_pkg.
`default_nettype none

interface cmdn_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [cmdn_pkg::PIX_W-1:0] pixel_in;

   modport source (output valid, output mode, output pixel_in, input ready);
   modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

`default_nettype wire

// File: rtl/cmdn_rsp_if.sv
// Result channel: filtered pixel and frame end flag with valid/ready.
// Depends on cmdn_pkg.
`default_nettype none

interface cmdn_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [cmdn_pkg::PIX_W-1:0] pixel_out;
   logic                      frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/cmdn_csr.sv
// APB register file: image width and height, plus clamped last-index values.
// Depends on cmdn_pkg.
`default_nettype none

module cmdn_csr #(
   parameter int MAX_WIDTH  = cmdn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cmdn_pkg::DEF_MAX_HEIGHT,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [cmdn_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [cmdn_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [cmdn_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output logic      [COL_W-1:0]                 width_last,
   output logic      [ROW_W-1:0]                 height_last
);
   import cmdn_pkg::*;

   localparam int WCMP_W = (WIDTH_REG_W > COL_W + 1) ? WIDTH_REG_W : COL_W + 1;
   localparam int HCMP_W = (HEIGHT_REG_W > ROW_W + 1) ? HEIGHT_REG_W : ROW_W + 1;
   localparam logic [COL_W-1:0]  WLAST_MAX = COL_W'(MAX_WIDTH - 1);
   localparam logic [ROW_W-1:0]  HLAST_MAX = ROW_W'(MAX_HEIGHT - 1);
   localparam logic [WCMP_W-1:0] WMAX_EXT  = WCMP_W'(MAX_WIDTH);
   localparam logic [HCMP_W-1:0] HMAX_EXT  = HCMP_W'(MAX_HEIGHT);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [WCMP_W-1:0]       width_ext;
   logic [HCMP_W-1:0]       height_ext;
   logic                    wr_strobe;
   reg_index_type           index;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;
   assign index     = reg_index_type'(paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_strobe) begin
         unique case (index)
            REG_IMAGE_WIDTH:  width_in  = pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // zero counts as one, oversize saturates
   assign width_ext  = WCMP_W'(width_ff);
   assign height_ext = HCMP_W'(height_ff);

   always_comb begin
      if (width_ff == '0)
         width_last = '0;
      else if (width_ext >= WMAX_EXT)
         width_last = WLAST_MAX;
      else
         width_last = COL_W'(width_ext - WCMP_W'(1));

      if (height_ff == '0)
         height_last = '0;
      else if (height_ext >= HMAX_EXT)
         height_last = HLAST_MAX;
      else
         height_last = ROW_W'(height_ext - HCMP_W'(1));
   end

endmodule

`default_nettype wire

// File: rtl/cmdn_linebuf.sv
// Two-row line store: one write port, two registered read ports,
// with same-edge write forwarding. Depends on cmdn_pkg.
`default_nettype none

module cmdn_linebuf #(
   parameter int DEPTH = cmdn_pkg::DEF_MAX_WIDTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire cmdn_pkg::line_pair_type  wr_data,
   input  wire logic [AW-1:0]            rd_addr_a,
   input  wire logic [AW-1:0]            rd_addr_b,
   output cmdn_pkg::line_pair_type       rd_data_a,
   output logic [cmdn_pkg::PIX_W-1:0]    rd_mid_b
);
   import cmdn_pkg::*;

   line_pair_type mem [DEPTH];
   line_pair_type rd_a_ff, rd_b_ff, fwd_ff;
   logic          fwd_a_ff, fwd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
      fwd_ff  <= wr_data;
   end

   // a read that collides with this edge's write takes the new word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_a_ff <= 1'b0;
         fwd_b_ff <= 1'b0;
      end else begin
         fwd_a_ff <= wr_en && (wr_addr == rd_addr_a);
         fwd_b_ff <= wr_en && (wr_addr == rd_addr_b);
      end
   end

   assign rd_data_a = fwd_a_ff ? fwd_ff : rd_a_ff;
   assign rd_mid_b  = fwd_b_ff ? fwd_ff.middle : rd_b_ff.middle;

endmodule

`default_nettype wire

// File: rtl/cmdn_median.sv
// Median of five pixels by rank counting (ties broken by position).
// Depends on cmdn_pkg.
`default_nettype none

module cmdn_median (
   input  wire logic [cmdn_pkg::PIX_W-1:0] centre,
   input  wire logic [cmdn_pkg::PIX_W-1:0] north,
   input  wire logic [cmdn_pkg::PIX_W-1:0] south,
   input  wire logic [cmdn_pkg::PIX_W-1:0] west,
   input  wire logic [cmdn_pkg::PIX_W-1:0] east,
   output logic      [cmdn_pkg::PIX_W-1:0] med
);
   import cmdn_pkg::*;

   logic [PIX_W-1:0]  v    [N_TAPS];
   logic [RANK_W-1:0] rank [N_TAPS];

   assign v[0] = centre;
   assign v[1] = north;
   assign v[2] = south;
   assign v[3] = west;
   assign v[4] = east;

   always_comb begin
      med = v[0];
      for (int i = 0; i < N_TAPS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < N_TAPS; j++) begin
            if (j != i && (v[j] < v[i] || (v[j] == v[i] && j < i)))
               rank[i] = rank[i] + RANK_W'(1);
         end
      end
      for (int i = 0; i < N_TAPS; i++) begin
         if (rank[i] == RANK_W'(MEDIAN_RANK))
            med = v[i];
      end
   end

endmodule

`default_nettype wire

// File: rtl/cmdn_outq.sv
// Two-entry result queue driving the result channel.
// Depends on cmdn_pkg and cmdn_rsp_if.
`default_nettype none

module cmdn_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cmdn_pkg::rsp_data_type push_data,
   output logic                       can_take,
   cmdn_rsp_if.source                 rsp_if
);
   import cmdn_pkg::*;

   rsp_data_type e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = rsp_if.valid & rsp_if.ready;
   assign can_take  = (count_ff != 2'd2);
   assign rsp_if.valid     = (count_ff != 2'd0);
   assign rsp_if.pixel_out = e0_ff.pixel_out;
   assign rsp_if.frame_end = e0_ff.frame_end;

   always_comb begin
      e0_in    = e0_ff;
      e1_in    = e1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) e0_in = push_data;
            else                  e1_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            e0_in    = e1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               e0_in = push_data;
            end else begin
               e0_in = e1_ff;
               e1_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

`default_nettype wire

// File: rtl/cross_median_denoise_core.sv
// Top level of the five-point cross median denoise filter.
// Depends on cmdn_pkg, cmdn_req_if, cmdn_rsp_if, cmdn_csr, cmdn_linebuf,
// cmdn_median, cmdn_outq and cross_median_denoise_core_defines.svh.
`default_nettype none

// Streams 8-bit grey pixels in raster order and returns, one row behind,
// the median of each pixel and its north/south/west/east neighbors, with
// edge replication. Every request is a pixel or a flush tick:
// a new request is accepted each cycle while the two-entry result queue
// has room, and its result enters the queue at the accepting edge, so it
// is on the result port the next cycle when the queue was empty. The
// first row produces nothing; after the last pixel of a frame, send
// image_width flush requests (mode = 1) to drain the final row, the last
// one carrying frame_end. Pixels sent while flushing and flush ticks sent
// outside a flush are dropped. The line store is a single
// MAX_WIDTH x 16-bit memory (row above and row two above packed per
// column) with one write and two registered reads per cycle; the reads
// are issued ahead of each request from the next column counter. A frame never
// reads an entry it has not written, so there is no clearing pass after
// reset. Register writes take effect at once; a counter at or past the
// new end counts as at the end. Widening image_width inside a frame is
// not supported. Registers: image_width at byte 0, image_height at byte 4.
module cross_median_denoise_core #(
   parameter int MAX_WIDTH  = cmdn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cmdn_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cmdn_req_if.sink                             req_if,
   cmdn_rsp_if.source                           rsp_if,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cmdn_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cmdn_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cmdn_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import cmdn_pkg::*;

`include "cross_median_denoise_core_defines.svh"

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam logic [COL_W-1:0] COL_TOP = COL_W'(MAX_WIDTH - 1);

   // configuration
   logic [COL_W-1:0] width_last;
   logic [ROW_W-1:0] height_last;

   // scan state
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] flush_count_ff, flush_count_in;
   logic             flushing_ff, flushing_in;
   logic             top_row_ff, top_row_in;
   logic [PIX_W-1:0] west_ff, west_in;

   // datapath
   logic             accept, pix_item, flush_item, push, outq_ready;
   logic [COL_W-1:0] col, rd_addr_a, rd_addr_b;
   logic             col_end, row_end;
   line_pair_type    rd_a, wr_word;
   logic [PIX_W-1:0] rd_mid_b;
   logic [PIX_W-1:0] centre, north, south, west, east, med;
   rsp_data_type     rsp_data;

   // checks
   logic             frame_done, scan_home;

   cmdn_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .width_last  (width_last),
      .height_last (height_last)
   );

   // request decode: out-of-place pixels and flush ticks are swallowed
   assign req_if.ready = outq_ready;
   assign accept     = req_if.valid & req_if.ready;
   assign pix_item   = accept & (req_if.mode == MODE_PIXEL) & ~flushing_ff;
   assign flush_item = accept & (req_if.mode == MODE_FLUSH) & flushing_ff;

   // column being output; a flush walks the last stored row
   assign col     = flushing_ff ? flush_count_ff : column_count_ff;
   assign col_end = (col >= width_last);
   assign row_end = (row_count_ff >= height_last);

   // window assembly with edge replication
   assign centre = rd_a.middle;
   assign north  = (flushing_ff ? top_row_ff : (row_count_ff == ROW_W'(1))) ?
                   centre : rd_a.upper;
   assign south  = flushing_ff ? centre : req_if.pixel_in;
   assign west   = (col == '0) ? centre : west_ff;
   assign east   = (col < width_last) ? rd_mid_b : centre;

   cmdn_median u_median (
      .centre (centre),
      .north  (north),
      .south  (south),
      .west   (west),
      .east   (east),
      .med    (med)
   );

   // next scan state
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      flush_count_in  = flush_count_ff;
      flushing_in     = flushing_ff;
      top_row_in      = top_row_ff;
      west_in         = west_ff;
      if (pix_item) begin
         west_in = centre;
         if (col_end) begin
            column_count_in = '0;
            if (row_end) begin
               top_row_in     = (row_count_ff == '0);
               row_count_in   = '0;
               flushing_in    = 1'b1;
               flush_count_in = '0;
            end else begin
               row_count_in = row_count_ff + ROW_W'(1);
            end
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end else if (flush_item) begin
         west_in = centre;
         if (col_end) begin
            flushing_in    = 1'b0;
            flush_count_in = '0;
         end else begin
            flush_count_in = flush_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         flush_count_ff  <= '0;
         flushing_ff     <= 1'b0;
         top_row_ff      <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         flush_count_ff  <= flush_count_in;
         flushing_ff     <= flushing_in;
         top_row_ff      <= top_row_in;
      end
   end

   always_ff @(posedge clock) begin
      west_ff <= west_in;
   end

   // line store: prefetch the column the next request will use
   assign rd_addr_a = reset ? '0 : (flushing_in ? flush_count_in : column_count_in);
   assign rd_addr_b = (rd_addr_a == COL_TOP) ? rd_addr_a : rd_addr_a + COL_W'(1);
   assign wr_word.upper  = centre;
   assign wr_word.middle = req_if.pixel_in;

   cmdn_linebuf #(
      .DEPTH (MAX_WIDTH)
   ) u_linebuf (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (pix_item & ~reset),
      .wr_addr   (column_count_ff),
      .wr_data   (wr_word),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_mid_b  (rd_mid_b)
   );

   // result: every row after the first, and every flush tick
   assign push               = (pix_item & (row_count_ff != '0)) | flush_item;
   assign rsp_data.pixel_out = med;
   assign rsp_data.frame_end = flush_item & col_end;

   cmdn_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rsp_data),
      .can_take  (outq_ready),
      .rsp_if    (rsp_if)
   );

   assign frame_done = push & rsp_data.frame_end;
   assign scan_home  = (column_count_ff == '0) && (row_count_ff == '0);

   `CMDN_ASSERT_SAME(a_flush_push, clock, reset, flush_item, push, "flush tick without result")
   `CMDN_ASSERT_NEXT(a_end_clears, clock, reset, frame_done, !flushing_ff, "still flushing")
   `CMDN_ASSERT_SAME(a_scan_idle, clock, reset, flushing_ff, scan_home, "scan moved in flush")

endmodule

`default_nettype wire

// File: bench/cross_median_denoise_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for cross_median_denoise_core: raster frames in, filtered row out.
// Depends on cmdn_pkg, cmdn_req_if, cmdn_rsp_if and the core itself.

module cross_median_denoise_core_test;
   import cmdn_pkg::*;

   localparam int MAX_W         = DEF_MAX_WIDTH;
   localparam int MAX_H         = DEF_MAX_HEIGHT;
   localparam int RANDOM_ITEMS  = 590;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // result enters the queue at the edge that accepts its request; leave margin
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic             mode;
      logic [PIX_W-1:0] pixel;
   } pixel_req_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_PATTERN,
      RDY_SPARSE
   } ready_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cmdn_req_if req_if();
   cmdn_rsp_if rsp_if();

   cross_median_denoise_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Filter predictor: own copy of registers, line stores and counters.
   // ------------------------------------------------------------------
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [PIX_W-1:0]        upper_row  [MAX_W];   // row two above the input row
   logic [PIX_W-1:0]        middle_row [MAX_W];   // row just above the input row
   int                      col_cnt;
   int                      row_cnt;
   int                      flush_cnt;
   bit                      flushing;
   bit                      top_row;              // flushed row is also the first row
   logic [PIX_W-1:0]        west_pix;             // center of previous output column

   pixel_req_type pending_q[$];    // requests waiting for the driver
   rsp_data_type  filtered_q[$];   // predicted filter outputs, oldest first
   int            mismatches = 0;
   int            cycles = 0;

   // zero reads as 1, anything past the store size saturates
   function automatic int clamp_dim(input int value, input int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // median of center and its four cross neighbors, edges replicated
   function automatic logic [PIX_W-1:0] cross_median(input int col, input int w, input bit top,
                                                     input logic [PIX_W-1:0] south_pix,
                                                     input bit south_edge);
      logic [PIX_W-1:0] taps [N_TAPS];
      logic [PIX_W-1:0] center_pix;
      int               below;
      int               same;
      center_pix = middle_row[col];
      taps[0] = center_pix;
      taps[1] = top ? center_pix : upper_row[col];
      taps[2] = south_edge ? center_pix : south_pix;
      taps[3] = (col == 0) ? center_pix : west_pix;
      taps[4] = (col + 1 < w && col + 1 < MAX_W) ? middle_row[col + 1] : center_pix;
      // pick the tap whose rank range covers the middle position
      for (int i = 0; i < N_TAPS; i++) begin
         below = 0;
         same  = 0;
         for (int j = 0; j < N_TAPS; j++) begin
            if (taps[j] < taps[i]) below++;
            else if (taps[j] == taps[i]) same++;
         end
         if (below <= MEDIAN_RANK && below + same > MEDIAN_RANK) return taps[i];
      end
      return center_pix;
   endfunction

   // advance the predictor by one accepted request; returns 1 when it yields a pixel
   function automatic bit denoise_step(input pixel_req_type req, output rsp_data_type res);
      int               w;
      int               h;
      int               col;
      logic [PIX_W-1:0] center_pix;
      bit               produced;
      w        = clamp_dim(width_reg, MAX_W);
      h        = clamp_dim(height_reg, MAX_H);
      produced = 1'b0;
      res      = '0;
      if (req.mode == MODE_PIXEL) begin
         if (flushing) return 1'b0;   // pixel during flush is dropped
         col        = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
         center_pix = middle_row[col];
         // first row is only stored; later rows emit the row above
         if (row_cnt != 0) begin
            res.pixel_out = cross_median(col, w, row_cnt == 1, req.pixel, 1'b0);
            res.frame_end = 1'b0;
            produced      = 1'b1;
         end
         upper_row[col]  = center_pix;
         middle_row[col] = req.pixel;
         west_pix        = center_pix;
         if (col_cnt >= w - 1) begin
            col_cnt = 0;
            if (row_cnt >= h - 1) begin
               top_row   = (row_cnt == 0);
               row_cnt   = 0;
               flushing  = 1'b1;
               flush_cnt = 0;
            end else begin
               row_cnt++;
            end
         end else begin
            col_cnt++;
         end
         return produced;
      end
      if (!flushing) return 1'b0;   // stray flush tick is dropped
      col           = (flush_cnt >= MAX_W) ? MAX_W - 1 : flush_cnt;
      center_pix    = middle_row[col];
      res.pixel_out = cross_median(col, w, top_row, '0, 1'b1);
      west_pix      = center_pix;
      if (flush_cnt >= w - 1) begin
         res.frame_end = 1'b1;
         flushing      = 1'b0;
         flush_cnt     = 0;
      end else begin
         res.frame_end = 1'b0;
         flush_cnt++;
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: tracks register writes and accepted requests, checks
   // every accepted result against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_data_type  res;
      rsp_data_type  want;
      pixel_req_type req;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_cnt    = 0;
         row_cnt    = 0;
         flush_cnt  = 0;
         flushing   = 1'b0;
         top_row    = 1'b0;
         west_pix   = '0;
         filtered_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:2]))
               REG_IMAGE_WIDTH:  width_reg  = pwdata[WIDTH_REG_W-1:0];
               REG_IMAGE_HEIGHT: height_reg = pwdata[HEIGHT_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            req.mode  = req_if.mode;
            req.pixel = req_if.pixel_in;
            if (denoise_step(req, res)) filtered_q.push_back(res);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (filtered_q.size() == 0) begin
               mismatches++;
               $error("unexpected result: pixel_out %0d frame_end %0b",
                      rsp_if.pixel_out, rsp_if.frame_end);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_if.pixel_out !== want.pixel_out) begin
                  mismatches++;
                  $error("pixel_out: expected %0d, actual %0d", want.pixel_out, rsp_if.pixel_out);
               end
               if (rsp_if.frame_end !== want.frame_end) begin
                  mismatches++;
                  $error("frame_end: expected %0b, actual %0b", want.frame_end, rsp_if.frame_end);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: bursts of back-to-back requests with random gaps between.
   // ------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      pixel_req_type req;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0 || pending_q.size() == 0) begin
            req_if.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            req = pending_q.pop_front();
            req_if.valid    <= 1'b1;
            req_if.mode     <= req.mode;
            req_if.pixel_in <= req.pixel;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // long streaming runs mixed with short choppy ones
               burst_left = $urandom_range(0, 1) ? $urandom_range(20, 120) : $urandom_range(0, 8);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result sink: ready follows a style that is redrawn at random when its run
   // ends (always, random, rotating pattern, mostly stalled).
   // ------------------------------------------------------------------
   ready_style_type ready_style = RDY_ALWAYS;
   logic [15:0]     ready_pattern;
   int              style_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         style_left = 0;
      end else begin
         if (style_left == 0) begin
            ready_style   = ready_style_type'($urandom_range(0, 3));
            ready_pattern = 16'($urandom);
            style_left    = $urandom_range(16, 256);
         end else begin
            style_left--;
         end
         case (ready_style)
            RDY_ALWAYS: rsp_if.ready <= 1'b1;
            RDY_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RDY_PATTERN: begin
               rsp_if.ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
            default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // block is idle once nothing is queued, in flight or owed; sampled
   // mid-cycle so the driver's updates at the edge have settled
   task automatic wait_idle();
      @(negedge clock);
      while (pending_q.size() != 0 || req_if.valid || filtered_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_req(input logic mode, input logic [PIX_W-1:0] pixel);
      pixel_req_type req;
      req.mode  = mode;
      req.pixel = pixel;
      pending_q.push_back(req);
   endfunction

   // salt-and-pepper heavy grey levels
   function automatic logic [PIX_W-1:0] grey_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one full frame plus its flush ticks; noise requests land where the core
   // drops them (flush tick before the frame completes, pixel during flush).
   // Returns the number of requests that count, noise excluded.
   function automatic int queue_frame(input int w, input int h, input int noise_pct);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 99) < noise_pct) push_req(MODE_FLUSH, PIX_W'($urandom));
         push_req(MODE_PIXEL, grey_level());
      end
      for (int i = 0; i < w; i++) begin
         if ($urandom_range(0, 99) < noise_pct) push_req(MODE_PIXEL, PIX_W'($urandom));
         push_req(MODE_FLUSH, PIX_W'($urandom));
      end
      return w * h + w;
   endfunction

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [PIX_W-1:0] grid [9];
      int               w;
      int               h;
      int               frames;
      int               random_items;

      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_if.valid    = 1'b0;
      req_if.mode     = MODE_PIXEL;
      req_if.pixel_in = '0;
      rsp_if.ready    = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // 3x3 frame of extremes: stray flush tick first, a pixel sent
      // during the flush, then the flush itself
      grid = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254};
      csr_write(REG_IMAGE_WIDTH, 3);
      csr_write(REG_IMAGE_HEIGHT, 3);
      push_req(MODE_FLUSH, 8'h5A);
      foreach (grid[i]) push_req(MODE_PIXEL, grid[i]);
      push_req(MODE_PIXEL, 8'd77);
      repeat (3) push_req(MODE_FLUSH, PIX_W'($urandom));
      wait_idle();

      // both registers zero: single-pixel frame, output only from the flush
      csr_write(REG_IMAGE_WIDTH, 0);
      csr_write(REG_IMAGE_HEIGHT, 0);
      push_req(MODE_PIXEL, 8'd200);
      push_req(MODE_FLUSH, 8'hFF);
      wait_idle();

      // one-row frame: west/east used only at flush time
      csr_write(REG_IMAGE_WIDTH, 2);
      csr_write(REG_IMAGE_HEIGHT, 1);
      push_req(MODE_PIXEL, 10);
      push_req(MODE_PIXEL, 250);
      push_req(MODE_FLUSH, 8'h00);
      push_req(MODE_FLUSH, 8'hA5);
      wait_idle();

      // width past the store size saturates: the row wraps after MAX_W
      // pixels and the flush starts; after a few ticks the width shrinks
      // to one pixel, so the next tick ends the frame
      csr_write(REG_IMAGE_WIDTH, 2047);
      csr_write(REG_IMAGE_HEIGHT, 1);
      for (int i = 0; i < MAX_W; i++) push_req(MODE_PIXEL, grey_level());
      repeat (4) push_req(MODE_FLUSH, PIX_W'($urandom));
      wait_idle();
      csr_write(REG_IMAGE_WIDTH, 1);
      push_req(MODE_FLUSH, PIX_W'($urandom));
      wait_idle();

      // random frames, mostly small, sometimes back to back without a
      // register change in between
      random_items = 0;
      w = 0;
      h = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (w == 0 || $urandom_range(0, 2) == 0) begin
            wait_idle();
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            h = $urandom_range(0, 6);
            csr_write(REG_IMAGE_WIDTH, w);
            csr_write(REG_IMAGE_HEIGHT, h);
            w = clamp_dim(w, MAX_W);
            h = clamp_dim(h, MAX_H);
         end
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames && random_items < RANDOM_ITEMS; f++)
            random_items += queue_frame(w, h, $urandom_range(0, 10));
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/cmdn_pkg.sv
rtl/cmdn_req_if.sv
rtl/cmdn_rsp_if.sv
rtl/cmdn_csr.sv
rtl/cmdn_linebuf.sv
rtl/cmdn_median.sv
rtl/cmdn_outq.sv
rtl/cross_median_denoise_core.sv
bench/cross_median_denoise_core_test.sv
